// ===== rtl/core/lsac_pkg.sv =====
package lsac_pkg;

  localparam int NumSensorsDef  = 16;
  localparam int SensorPitchDef = 4000;
  localparam logic [7:0] ThresholdRst = 8'd45;
  localparam logic [4:0] FirstNone    = 5'd17;

  typedef enum logic [1:0] {
    CAL_RUN   = 2'd0,
    CAL_WHITE = 2'd1,
    CAL_BLACK = 2'd2
  } cal_mode_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_CAL_MODE  = 1'b1
  } reg_idx_t;

  // one queued word: channel and median of an accepted item
  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] median;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_CDIV,
    ST_OUT
  } back_state_t;

endpackage

// ===== rtl/core/lsac_if.sv =====
interface lsac_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_first;
  logic [15:0] sample_second;
  logic [15:0] sample_third;
  modport source (output valid, sample_first, sample_second, sample_third, input ready);
  modport sink (input valid, sample_first, sample_second, sample_third, output ready);
endinterface

// ===== rtl/core/lsac_out_if.sv =====
interface lsac_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic [15:0]        raw_median;
  logic [7:0]         level;
  logic [15:0]        line_bits;
  logic signed [15:0] position;
  logic [4:0]         window_first;
  logic [3:0]         window_last;
  logic               position_updated;
  modport source (output valid, channel, raw_median, level, line_bits, position,
                  window_first, window_last, position_updated, input ready);
  modport sink (input valid, channel, raw_median, level, line_bits, position,
                window_first, window_last, position_updated, output ready);
endinterface

// ===== rtl/core/lsac_cfg_if.sv =====
interface lsac_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [7:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lsac_front.sv =====
module lsac_front #(
  parameter int NUM_SENSORS = lsac_pkg::NumSensorsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    in_a,
  input  logic [15:0]    in_b,
  input  logic [15:0]    in_c,
  output logic           q_valid,
  input  logic           q_pop,
  output lsac_pkg::job_t q_word
);

  // two-entry queue of medians between front and back
  lsac_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [3:0] ch_r;
  logic [15:0] lo, hi, m, med;
  logic push;

  // median of three
  always_comb begin
    lo  = (in_a < in_b) ? in_a : in_b;
    hi  = (in_a < in_b) ? in_b : in_a;
    m   = (hi < in_c) ? hi : in_c;
    med = (lo > m) ? lo : m;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{channel: ch_r, median: med};
    end
  end

  // advance pointers and channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0; ch_r <= 4'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        ch_r <= (ch_r == 4'(NUM_SENSORS - 1)) ? 4'd0 : ch_r + 4'd1;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/core/lsac_back.sv =====
module lsac_back #(
  parameter int NUM_SENSORS  = lsac_pkg::NumSensorsDef,
  parameter int SENSOR_PITCH = lsac_pkg::SensorPitchDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         threshold,
  input  logic [1:0]         cal_mode,
  input  logic               q_valid,
  output logic               q_pop,
  input  lsac_pkg::job_t     q_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel,
  output logic [15:0]        out_raw_median,
  output logic [7:0]         out_level,
  output logic [15:0]        out_line_bits,
  output logic signed [15:0] out_position,
  output logic [4:0]         out_window_first,
  output logic [3:0]         out_window_last,
  output logic               out_position_updated
);

  localparam int Half   = ((NUM_SENSORS - 1) * SENSOR_PITCH) / 2;
  localparam int Base   = NUM_SENSORS / 2 - 3;
  // reciprocal of the pitch, exact for any magnitude below 2^16
  localparam int RecipShift = 16 + $clog2(SENSOR_PITCH);
  localparam logic [31:0] Recip = 32'(((64'd1 << RecipShift) + 64'(SENSOR_PITCH)
                                       - 64'd1) / 64'(SENSOR_PITCH));

  lsac_pkg::back_state_t st_r, st_nxt;

  logic [15:0] wmax_r [16];
  logic [15:0] bmax_r [16];
  logic [7:0]  lvl_r  [16];
  logic [15:0] bits_r;
  logic signed [15:0] pos_r;
  logic [4:0]  wf_r;
  logic [3:0]  wl_r;
  logic        upd_r;
  logic [3:0]  ch_r;
  logic [15:0] med_r;
  logic [7:0]  lvlo_r;

  // shared restoring divider: num / den, one quotient bit a cycle
  logic [39:0] rem_r;
  logic [39:0] num_r;
  logic [29:0] den_r;
  logic [5:0]  it_r;
  logic        neg_r;
  logic [40:0] trial;

  // window walk
  logic [4:0]  k_r;
  logic signed [17:0] lo_r;
  logic signed [39:0] acc_r;
  logic [11:0] wsum_r;

  logic [15:0] wm, bm, wm_n, bm_n;
  logic        st_done;
  logic signed [31:0] cpos;
  logic signed [5:0] kk;
  logic signed [17:0] kx;
  logic [15:0] pmag;
  logic [47:0] qprod;
  logic [15:0] qmag;
  logic signed [16:0] qd;
  logic signed [40:0] qs;

  assign q_pop = (st_r == lsac_pkg::ST_IDLE) && q_valid;
  assign trial = {rem_r, num_r[39]} - {11'd0, den_r};

  // calibration-adjusted maxima of the current word
  always_comb begin
    wm = wmax_r[q_word.channel];
    bm = bmax_r[q_word.channel];
    wm_n = wm;
    bm_n = bm;
    if (cal_mode == lsac_pkg::CAL_WHITE && q_word.median > wm) wm_n = q_word.median;
    else if (cal_mode == lsac_pkg::CAL_BLACK && q_word.median > bm) bm_n = q_word.median;
  end

  // window origin: position over pitch, truncated toward zero
  assign pmag  = pos_r[15] ? 16'(-pos_r) : 16'(pos_r);
  assign qprod = {32'd0, pmag} * {16'd0, Recip};
  assign qmag  = 16'(qprod >> RecipShift);
  assign qd    = pos_r[15] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  assign kk   = $signed({1'b0, k_r});
  assign kx   = 18'(kk);
  assign cpos = SENSOR_PITCH * 32'(kk) - Half;
  assign qs   = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
  assign st_done = (it_r == 6'd0);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lsac_pkg::ST_IDLE: if (q_valid) st_nxt = lsac_pkg::ST_DIV;
      lsac_pkg::ST_DIV:
        if (st_done) st_nxt = (ch_r == 4'd0 || ch_r == 4'(NUM_SENSORS - 1)) ?
                              lsac_pkg::ST_ACC : lsac_pkg::ST_OUT;
      lsac_pkg::ST_ACC:
        if (k_r == 5'(NUM_SENSORS)) st_nxt = lsac_pkg::ST_CDIV;
      lsac_pkg::ST_CDIV: if (st_done) st_nxt = lsac_pkg::ST_OUT;
      lsac_pkg::ST_OUT: if (out_ready) st_nxt = lsac_pkg::ST_IDLE;
      default: st_nxt = lsac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= lsac_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        wmax_r[i] <= '0; bmax_r[i] <= '0; lvl_r[i] <= '0;
      end
      bits_r <= '0; pos_r <= '0; wf_r <= lsac_pkg::FirstNone; wl_r <= '0;
      upd_r <= 1'b0;
    end else begin
      case (st_r)
        lsac_pkg::ST_IDLE: if (q_valid) begin
          ch_r  <= q_word.channel;
          med_r <= q_word.median;
          wmax_r[q_word.channel] <= wm_n;
          bmax_r[q_word.channel] <= bm_n;
          rem_r <= '0;
          neg_r <= 1'b0;
          if (q_word.median < bm_n) begin
            lvlo_r <= 8'd0; it_r <= 6'd0; num_r <= '0;
          end else if (q_word.median > wm_n) begin
            lvlo_r <= 8'd255; it_r <= 6'd0; num_r <= '0;
          end else if (wm_n == bm_n) begin
            lvlo_r <= 8'd0; it_r <= 6'd0; num_r <= '0;
          end else begin
            lvlo_r <= 8'd0;
            num_r  <= {16'd0, 24'(({8'd0, q_word.median - bm_n} << 8)
                                   - {8'd0, q_word.median - bm_n})} << 16;
            den_r  <= {14'd0, wm_n - bm_n};
            it_r   <= 6'd24;
          end
        end
        lsac_pkg::ST_DIV: begin
          if (!st_done) begin
            if (!trial[40]) rem_r <= trial[39:0];
            else            rem_r <= {rem_r[38:0], num_r[39]};
            num_r <= {num_r[38:0], ~trial[40]};
            it_r  <= it_r - 6'd1;
          end else begin
            if (den_r != '0 && it_r == 6'd0 && lvlo_r == 8'd0 && rem_r != 40'h0 ||
                den_r != '0)
              lvlo_r <= lvlo_r | num_r[7:0];
            lvl_r[ch_r] <= lvlo_r | num_r[7:0];
            bits_r[4'd15 - ch_r] <= ((lvlo_r | num_r[7:0]) > threshold);
            den_r <= '0;
            num_r <= '0;
            k_r   <= '0;
            acc_r <= '0;
            wsum_r <= '0;
            // reopen the window only on a recompute channel
            if (ch_r == 4'd0 || ch_r == 4'(NUM_SENSORS - 1)) begin
              wf_r  <= lsac_pkg::FirstNone;
              wl_r  <= '0;
            end
            lo_r  <= 18'(qd) + 18'(Base);
            upd_r <= (ch_r == 4'd0 || ch_r == 4'(NUM_SENSORS - 1));
          end
        end
        lsac_pkg::ST_ACC: if (k_r != 5'(NUM_SENSORS)) begin
          // one window sensor a cycle
          if (kx >= lo_r && kx <= lo_r + 18'sd5) begin
            if (wf_r == lsac_pkg::FirstNone) wf_r <= k_r;
            wl_r   <= k_r[3:0];
            acc_r  <= acc_r + 40'(cpos * $signed({24'd0, lvl_r[k_r[3:0]]}));
            wsum_r <= wsum_r + {4'd0, lvl_r[k_r[3:0]]};
          end
          k_r <= k_r + 5'd1;
        end else begin
          neg_r <= acc_r[39];
          num_r <= (wsum_r == '0) ? 40'd0 : (acc_r[39] ? 40'(-acc_r) : 40'(acc_r));
          den_r <= {18'd0, wsum_r};
          rem_r <= '0;
          it_r  <= (wsum_r == '0) ? 6'd0 : 6'd40;
        end
        lsac_pkg::ST_CDIV: begin
          if (!st_done) begin
            if (!trial[40]) rem_r <= trial[39:0];
            else            rem_r <= {rem_r[38:0], num_r[39]};
            num_r <= {num_r[38:0], ~trial[40]};
            it_r  <= it_r - 6'd1;
          end else begin
            if (qs > 41'sd32767)       pos_r <= 16'sd32767;
            else if (qs < -41'sd32768) pos_r <= -16'sd32768;
            else                       pos_r <= qs[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid            = (st_r == lsac_pkg::ST_OUT);
  assign out_channel          = ch_r;
  assign out_raw_median       = med_r;
  assign out_level            = lvl_r[ch_r];
  assign out_line_bits        = bits_r;
  assign out_position         = pos_r;
  assign out_window_first     = wf_r;
  assign out_window_last      = wl_r;
  assign out_position_updated = upd_r;

endmodule

// ===== rtl/core/line_sensor_array_centroid.sv =====
// Line sensor array centroid.
// in_*  : one word per channel, three ADC samples; the channel comes from an
//         internal counter that wraps at NUM_SENSORS.
// out_* : one word per input word: channel, median, level, line bits,
//         centroid position and window bounds, position_updated on the first
//         and last channel.
// cfg_* : index 0 threshold, index 1 calibration mode; write only when idle.
// Input medians are queued two deep, so the front keeps taking words while
// the back works. The back takes a word, runs the level divider, and on the
// recompute channels 0 and last walks the window and runs the centroid
// division, then holds the result until out_ready. It takes no new word
// until that result has left; the shared bit-serial divider sets how long
// an item takes.
// Reset clears the channel counter, calibration maxima, levels and line bits,
// sets position 0 and window 17..0. A stalled receiver holds the result and
// backs the queue up into in_ready.
module line_sensor_array_centroid #(
  parameter int NUM_SENSORS  = lsac_pkg::NumSensorsDef,
  parameter int SENSOR_PITCH = lsac_pkg::SensorPitchDef
) (
  input logic clk,
  input logic rst_n,
  lsac_in_if.sink     in_ch,
  lsac_out_if.source  out_ch,
  lsac_cfg_if.sink    cfg_ch
);

  logic [7:0] thr_r;
  logic [1:0] mode_r;
  logic q_valid, q_pop;
  lsac_pkg::job_t q_word;

  // hold configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= lsac_pkg::ThresholdRst; mode_r <= lsac_pkg::CAL_RUN;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == lsac_pkg::REG_THRESHOLD) thr_r <= cfg_ch.data;
      else mode_r <= cfg_ch.data[1:0];
    end
  end

  lsac_front #(.NUM_SENSORS(NUM_SENSORS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_a(in_ch.sample_first), .in_b(in_ch.sample_second), .in_c(in_ch.sample_third),
    .q_valid, .q_pop, .q_word
  );

  lsac_back #(.NUM_SENSORS(NUM_SENSORS), .SENSOR_PITCH(SENSOR_PITCH)) u_back (
    .clk, .rst_n, .threshold(thr_r), .cal_mode(mode_r),
    .q_valid, .q_pop, .q_word,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_channel(out_ch.channel), .out_raw_median(out_ch.raw_median),
    .out_level(out_ch.level), .out_line_bits(out_ch.line_bits),
    .out_position(out_ch.position), .out_window_first(out_ch.window_first),
    .out_window_last(out_ch.window_last),
    .out_position_updated(out_ch.position_updated)
  );

  // the back pops only when the queue holds a word
  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_level_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.level > thr_r) |-> out_ch.line_bits[4'd15 - out_ch.channel])
    else $error("line bit disagrees with level");
  a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.window_first == lsac_pkg::FirstNone) |->
    (out_ch.position == 16'sd0)) else $error("empty window with nonzero position");

endmodule
